// ===== design/lapic_pkg.sv =====
// ----------------------------------------------------------------------------
// lapic_pkg
// Shared types and constants for the local interrupt controller timer.
// ----------------------------------------------------------------------------
package lapic_pkg;

	localparam int COUNT_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	localparam logic [9:0] OFF_LVT  = 10'h320;
	localparam logic [9:0] OFF_INIT = 10'h380;
	localparam logic [9:0] OFF_CURR = 10'h390;
	localparam logic [9:0] OFF_DIV  = 10'h3e0;

	localparam logic [1:0] MODE_PERIODIC = 2'b01;
	localparam logic [3:0] DIV_KEEP_BITS = 4'b1011;

	// bit positions in the LVT timer register
	localparam int LVT_MASK_BIT = 16;
	localparam int LVT_MODE_LSB = 17;

	typedef struct packed {
		opcode_t     opcode;
		logic [9:0]  reg_offset;
		logic [31:0] write_data;
	} item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_fire;
		logic [7:0]  irq_vector;
	} result_t;

endpackage

// ===== design/lapic_chan_if.sv =====
// ----------------------------------------------------------------------------
// lapic_chan_if
// Valid/ready channel carrying one item of type data_t.
// ----------------------------------------------------------------------------
interface lapic_chan_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/lapic_tmr_core.sv =====
// ----------------------------------------------------------------------------
// lapic_tmr_core
// Timer registers, prescaler and down-counter; one item processed per step.
// ----------------------------------------------------------------------------
module lapic_tmr_core #(
	parameter int COUNT_WIDTH = lapic_pkg::COUNT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  lapic_pkg::item_t   item,
	output lapic_pkg::result_t res
);

	logic [7:0]             vec_q, vec_n;
	logic                   masked_q, masked_n;
	logic [1:0]             mode_q, mode_n;
	logic [COUNT_WIDTH-1:0] init_q, init_n;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_n;
	logic [3:0]             div_q, div_n;
	logic [6:0]             psc_q, psc_n;

	logic [COUNT_WIDTH-1:0] cnt_dec;
	logic [6:0]             psc_inc;
	logic [2:0]             div_log2;
	logic                   dec_en;
	logic [63:0]            wd_ext;
	logic [63:0]            init_ext;
	logic [63:0]            cnt_ext;
	logic                   fire;
	logic [31:0]            rd;

	assign cnt_dec  = cnt_q - COUNT_WIDTH'(1);
	assign psc_inc  = psc_q + 7'd1;
	assign div_log2 = {div_q[3], div_q[1:0]} + 3'd1;
	assign dec_en   = (div_log2 == 3'd7) ? (psc_inc == 7'd0)
		: ({1'b0, psc_inc} >= (8'd1 << div_log2));
	assign wd_ext   = {32'd0, item.write_data};
	assign init_ext = 64'(init_q);
	assign cnt_ext  = 64'(cnt_q);

	always_comb begin
		vec_n    = vec_q;
		masked_n = masked_q;
		mode_n   = mode_q;
		init_n   = init_q;
		cnt_n    = cnt_q;
		div_n    = div_q;
		psc_n    = psc_q;
		fire     = 1'b0;
		rd       = '0;
		case (item.opcode)
			lapic_pkg::OP_TICK: begin
				if (cnt_q != '0) begin
					psc_n = psc_inc;
					if (dec_en) begin
						psc_n = '0;
						cnt_n = cnt_dec;
						if (cnt_dec == '0) begin
							if (mode_q == lapic_pkg::MODE_PERIODIC) begin
								cnt_n = init_q;
							end
							fire = !masked_q;
						end
					end
				end
			end
			lapic_pkg::OP_WRITE: begin
				unique case (item.reg_offset)
					lapic_pkg::OFF_LVT: begin
						vec_n    = item.write_data[7:0];
						masked_n = item.write_data[lapic_pkg::LVT_MASK_BIT];
						mode_n   = item.write_data[lapic_pkg::LVT_MODE_LSB +: 2];
					end
					lapic_pkg::OFF_INIT: begin
						init_n = wd_ext[COUNT_WIDTH-1:0];
						cnt_n  = wd_ext[COUNT_WIDTH-1:0];
						psc_n  = '0;
					end
					lapic_pkg::OFF_DIV: begin
						div_n = item.write_data[3:0] & lapic_pkg::DIV_KEEP_BITS;
						psc_n = '0;
					end
					default: ;
				endcase
			end
			lapic_pkg::OP_READ: begin
				unique case (item.reg_offset)
					lapic_pkg::OFF_LVT:  rd = {13'd0, mode_q, masked_q, 8'd0, vec_q};
					lapic_pkg::OFF_INIT: rd = init_ext[31:0];
					lapic_pkg::OFF_CURR: rd = cnt_ext[31:0];
					lapic_pkg::OFF_DIV:  rd = {28'd0, div_q};
					default:             rd = '0;
				endcase
			end
			default: ;
		endcase
	end

	assign res.read_data  = rd;
	assign res.irq_fire   = fire;
	assign res.irq_vector = fire ? vec_q : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_q    <= '0;
			masked_q <= 1'b1;
			mode_q   <= '0;
			init_q   <= '0;
			cnt_q    <= '0;
			div_q    <= '0;
			psc_q    <= '0;
		end else if (step) begin
			vec_q    <= vec_n;
			masked_q <= masked_n;
			mode_q   <= mode_n;
			init_q   <= init_n;
			cnt_q    <= cnt_n;
			div_q    <= div_n;
			psc_q    <= psc_n;
		end
	end

endmodule

// ===== design/local_apic_timer.sv =====
// ----------------------------------------------------------------------------
// local_apic_timer
// Local interrupt controller timer: ticks, register writes and reads in,
// one result out per item.
// ----------------------------------------------------------------------------
// Item accept to result valid passes the input reg, then the result reg.
// Throughput: 1 item per cycle unless rsp stalls; one counter update per item.
// Reset (arst_n low): pipeline empty, timer masked, one-shot, counts zero,
// divide code zero (divide by two), prescaler cleared.
// ----------------------------------------------------------------------------
module local_apic_timer #(
	parameter int COUNT_WIDTH = lapic_pkg::COUNT_WIDTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	lapic_chan_if.sink   req,
	lapic_chan_if.source rsp
);

	logic               valid_s1;
	lapic_pkg::item_t   item_s1;
	logic               rsp_valid_q;
	lapic_pkg::result_t rsp_data_q;
	lapic_pkg::result_t res;
	logic               advance;
	logic               step;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign step      = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
	end

	lapic_tmr_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.item  (item_s1),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rsp_data_q <= res;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

`ifndef SYNTHESIS
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost item while stalled");

	a_fire_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_data_q.irq_fire |-> rsp_data_q.read_data == '0)
		else $error("interrupt reported with read data");

	a_vec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_data_q.irq_fire |-> rsp_data_q.irq_vector == '0)
		else $error("vector without interrupt");

	a_step_fill: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> rsp_valid_q)
		else $error("processed item did not reach result register");
`endif

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for local_apic_timer. A queue of bus items (clock ticks,
// register writes and reads) is filled up front: directed register and expiry
// checks, then random timer programming sequences followed by tick runs, mixed
// with stray accesses. A predictor tracks the timer registers and scores every
// result in order, while both sides of the channel stall in random bursts.
// ----------------------------------------------------------------------------
module testbench;

	localparam int ITEM_TARGET = 1700;
	localparam int TAIL_ITEMS = 120;
	localparam int MAX_REPORTS = 100;

	logic clk;
	logic arst_n;

	lapic_chan_if #(.data_t(lapic_pkg::item_t)) req ();
	lapic_chan_if #(.data_t(lapic_pkg::result_t)) rsp ();

	local_apic_timer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	lapic_pkg::item_t pending_items[$];
	lapic_pkg::result_t expected_results[$];
	lapic_pkg::result_t want_res;
	int mismatch_count;
	int send_hold;
	int recv_hold;
	logic [31:0] cycle_no;
	logic [9:0] reg_map[4] = '{lapic_pkg::OFF_LVT, lapic_pkg::OFF_INIT,
		lapic_pkg::OFF_CURR, lapic_pkg::OFF_DIV};

	// predicted timer state
	logic [7:0] tmr_vector;
	logic tmr_masked;
	logic [1:0] tmr_mode;
	logic [31:0] tmr_init;
	logic [31:0] tmr_count;
	logic [3:0] tmr_divcode;
	logic [6:0] tmr_prescale;

	function automatic int unsigned divide_ratio(logic [3:0] code);
		logic [2:0] sel;
		sel = {code[3], code[1:0]} + 3'd1;
		return 1 << sel;
	endfunction

	function automatic bit idling_allowed();
		return cycle_no[9:8] != 2'd0 && pending_items.size() > TAIL_ITEMS;
	endfunction

	function automatic lapic_pkg::result_t timer_step(lapic_pkg::item_t it);
		lapic_pkg::result_t r;
		int unsigned ratio;
		r = '0;
		case (it.opcode)
			lapic_pkg::OP_TICK: if (tmr_count != 0) begin
				ratio = divide_ratio(tmr_divcode);
				tmr_prescale = tmr_prescale + 7'd1;
				if (ratio == 128 ? tmr_prescale == 0 : tmr_prescale >= ratio) begin
					tmr_prescale = '0;
					tmr_count = tmr_count - 32'd1;
					if (tmr_count == 0) begin
						if (tmr_mode == lapic_pkg::MODE_PERIODIC)
							tmr_count = tmr_init;
						if (!tmr_masked) begin
							r.irq_fire = 1'b1;
							r.irq_vector = tmr_vector;
						end
					end
				end
			end
			lapic_pkg::OP_WRITE: case (it.reg_offset)
				lapic_pkg::OFF_LVT: begin
					tmr_vector = it.write_data[7:0];
					tmr_masked = it.write_data[lapic_pkg::LVT_MASK_BIT];
					tmr_mode = it.write_data[lapic_pkg::LVT_MODE_LSB +: 2];
				end
				lapic_pkg::OFF_INIT: begin
					tmr_init = it.write_data;
					tmr_count = it.write_data;
					tmr_prescale = '0;
				end
				lapic_pkg::OFF_DIV: begin
					tmr_divcode = it.write_data[3:0] & lapic_pkg::DIV_KEEP_BITS;
					tmr_prescale = '0;
				end
				default: ;
			endcase
			lapic_pkg::OP_READ: case (it.reg_offset)
				lapic_pkg::OFF_LVT: begin
					r.read_data[7:0] = tmr_vector;
					r.read_data[lapic_pkg::LVT_MASK_BIT] = tmr_masked;
					r.read_data[lapic_pkg::LVT_MODE_LSB +: 2] = tmr_mode;
				end
				lapic_pkg::OFF_INIT: r.read_data = tmr_init;
				lapic_pkg::OFF_CURR: r.read_data = tmr_count;
				lapic_pkg::OFF_DIV: r.read_data = {28'd0, tmr_divcode};
				default: ;
			endcase
			default: ;
		endcase
		return r;
	endfunction

	task automatic queue_item(lapic_pkg::opcode_t op, logic [9:0] off, logic [31:0] data);
		pending_items.push_back(lapic_pkg::item_t'{opcode: op, reg_offset: off,
			write_data: data});
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// driver: feeds the request channel and predicts each accepted item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.data <= '0;
			send_hold <= 0;
			tmr_vector = '0;
			tmr_masked = 1'b1;
			tmr_mode = '0;
			tmr_init = '0;
			tmr_count = '0;
			tmr_divcode = '0;
			tmr_prescale = '0;
		end else begin
			if (req.valid && req.ready)
				expected_results.push_back(timer_step(req.data));
			if (!req.valid || req.ready) begin
				if (send_hold > 0) begin
					req.valid <= 1'b0;
					send_hold <= send_hold - 1;
				end else if (pending_items.size() > 0) begin
					req.valid <= 1'b1;
					req.data <= pending_items.pop_front();
					if (idling_allowed() && $urandom_range(0, 11) == 0)
						send_hold <= $urandom_range(1, 18);
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: stalls the result channel and scores each result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			recv_hold <= 0;
			cycle_no <= '0;
		end else begin
			cycle_no <= cycle_no + 32'd1;
			if (recv_hold > 0) begin
				rsp.ready <= 1'b0;
				recv_hold <= recv_hold - 1;
			end else if (idling_allowed() && $urandom_range(0, 11) == 0) begin
				rsp.ready <= 1'b0;
				recv_hold <= $urandom_range(0, 17);
			end else begin
				rsp.ready <= 1'b1;
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$error("unexpected result: read_data %h irq_fire %b irq_vector %h",
							rsp.data.read_data, rsp.data.irq_fire, rsp.data.irq_vector);
				end else begin
					want_res = expected_results.pop_front();
					if (rsp.data.read_data !== want_res.read_data) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$error("read_data: expected %h, got %h",
								want_res.read_data, rsp.data.read_data);
					end
					if (rsp.data.irq_fire !== want_res.irq_fire) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$error("irq_fire: expected %b, got %b",
								want_res.irq_fire, rsp.data.irq_fire);
					end
					if (rsp.data.irq_vector !== want_res.irq_vector) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$error("irq_vector: expected %h, got %h",
								want_res.irq_vector, rsp.data.irq_vector);
					end
				end
			end
		end
	end

	initial begin
		logic [3:0] code;
		int unsigned ratio;
		int unsigned count;
		int unsigned n_ticks;
		logic [31:0] lvt_word;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		mismatch_count = 0;
		arst_n = 1'b0;

		// reset values, stopped counter, register layouts
		queue_item(lapic_pkg::OP_READ, lapic_pkg::OFF_LVT, 32'h0);
		queue_item(lapic_pkg::OP_READ, lapic_pkg::OFF_INIT, 32'h0);
		queue_item(lapic_pkg::OP_READ, lapic_pkg::OFF_CURR, 32'h0);
		queue_item(lapic_pkg::OP_READ, lapic_pkg::OFF_DIV, 32'h0);
		queue_item(lapic_pkg::OP_TICK, 10'h0, 32'h0);
		queue_item(lapic_pkg::OP_WRITE, lapic_pkg::OFF_LVT, 32'hFFFF_FFFF);
		queue_item(lapic_pkg::OP_READ, lapic_pkg::OFF_LVT, 32'h0);
		queue_item(lapic_pkg::OP_WRITE, lapic_pkg::OFF_DIV, 32'hFFFF_FFFF);
		queue_item(lapic_pkg::OP_READ, lapic_pkg::OFF_DIV, 32'h0);
		queue_item(lapic_pkg::OP_WRITE, lapic_pkg::OFF_INIT, 32'hFFFF_FFFF);
		queue_item(lapic_pkg::OP_READ, lapic_pkg::OFF_CURR, 32'h0);
		// current count is read-only
		queue_item(lapic_pkg::OP_WRITE, lapic_pkg::OFF_CURR, 32'h1234_5678);
		queue_item(lapic_pkg::OP_TICK, 10'h3FF, 32'hFFFF_FFFF);
		queue_item(lapic_pkg::OP_READ, lapic_pkg::OFF_CURR, 32'h0);
		// unaligned and unmapped accesses, no-op opcode
		queue_item(lapic_pkg::OP_WRITE, lapic_pkg::OFF_LVT + 10'd1, 32'h0001_0042);
		queue_item(lapic_pkg::OP_READ, 10'h3FF, 32'h0);
		queue_item(lapic_pkg::OP_NOP, lapic_pkg::OFF_LVT, 32'hFFFF_FFFF);
		// periodic, unmasked, low vector, divide by one
		queue_item(lapic_pkg::OP_WRITE, lapic_pkg::OFF_LVT, 32'h0002_0005);
		queue_item(lapic_pkg::OP_WRITE, lapic_pkg::OFF_INIT, 32'h2);
		repeat (5) queue_item(lapic_pkg::OP_TICK, 10'h0, 32'h0);
		queue_item(lapic_pkg::OP_WRITE, lapic_pkg::OFF_INIT, 32'h0);
		queue_item(lapic_pkg::OP_TICK, 10'h0, 32'h0);
		queue_item(lapic_pkg::OP_READ, 10'h000, 32'h0);

		while (pending_items.size() < ITEM_TARGET) begin
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 6))
					queue_item(lapic_pkg::opcode_t'($urandom_range(0, 3)),
						$urandom_range(0, 1) ? reg_map[$urandom_range(0, 3)]
							: 10'($urandom_range(0, 1023)),
						$urandom());
			end else begin
				code = 4'($urandom_range(0, 15));
				if (divide_ratio(code) > 8 && $urandom_range(0, 3) != 0) begin
					case ($urandom_range(0, 2))
						0: code = 4'b1011;
						1: code = 4'b0000;
						default: code = 4'b0001;
					endcase
					code[2] = 1'($urandom_range(0, 1));
				end
				ratio = divide_ratio(code);
				queue_item(lapic_pkg::OP_WRITE, lapic_pkg::OFF_DIV,
					($urandom() & 32'hFFFF_FFF0) | {28'd0, code});
				lvt_word = $urandom();
				lvt_word[lapic_pkg::LVT_MASK_BIT] = ($urandom_range(0, 3) == 0);
				queue_item(lapic_pkg::OP_WRITE, lapic_pkg::OFF_LVT, lvt_word);
				if ($urandom_range(0, 19) == 0)
					count = $urandom();
				else if ($urandom_range(0, 19) == 0)
					count = 0;
				else
					count = ratio >= 32 ? $urandom_range(1, 3) : $urandom_range(1, 12);
				queue_item(lapic_pkg::OP_WRITE, lapic_pkg::OFF_INIT, count);
				n_ticks = count * ratio
					* (lvt_word[lapic_pkg::LVT_MODE_LSB +: 2] == lapic_pkg::MODE_PERIODIC
						? 2 : 1)
					+ $urandom_range(0, 4);
				if (count > 400 || n_ticks > 400)
					n_ticks = $urandom_range(20, 60);
				repeat (n_ticks) begin
					queue_item(lapic_pkg::OP_TICK, 10'($urandom_range(0, 1023)), $urandom());
					if ($urandom_range(0, 7) == 0)
						queue_item(lapic_pkg::OP_READ, reg_map[$urandom_range(0, 3)],
							$urandom());
					if ($urandom_range(0, 59) == 0)
						queue_item(lapic_pkg::OP_WRITE, lapic_pkg::OFF_INIT,
							$urandom_range(1, 8));
					if ($urandom_range(0, 79) == 0)
						queue_item(lapic_pkg::OP_WRITE, lapic_pkg::OFF_DIV,
							$urandom_range(0, 15));
				end
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_items.size() != 0 || req.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
